// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // most bytes one input byte can release
  localparam int BURST_MAX = 5;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);
  localparam int IDX_W     = $clog2(BURST_MAX);

  // descriptor queue between front and back, depth a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_HT = 8'h09;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;

  // utf-8 limits and marks
  localparam logic [15:0] UTF8_ONE_LIM = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIM = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX0  = 3'd2,
    MODE_HEX1  = 3'd3,
    MODE_HEX2  = 3'd4,
    MODE_HEX3  = 3'd5
  } mode_t;

  // bytes released by one input byte
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } desc_t;

  // a descriptor with its valid flag, on either side of the queue
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } slot_t;

  // {ok, value} of one hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output for backslash-u escapes.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// -------  ---------  --------------------  -------------------------------
// in       sink       in_valid / in_ready   in_byte, in_last
// out      source     out_valid / out_ready out_byte, run_last, string_end
//
// one request is taken per cycle while the descriptor queue has room; each
// request releases zero to five bytes, sent one byte per cycle while out_ready
// is high; sustained rate is one request per cycle when requests release at
// most one byte and out_ready stays high; longer bursts are bounded by the
// one-byte-per-cycle output register; a released byte goes through the queue
// memory and then the output register; rst is synchronous and clears escape
// state, queue pointers, serialiser index and out_valid; the four-entry queue
// lets the decoder run ahead while the output stalls
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  slot_t push;    // decoded burst from the front
  slot_t head;    // oldest burst waiting for the back
  logic  q_full;
  logic  pop;
  logic  accept;

  // requests that release nothing still need a slot check, which keeps
  // in_ready independent of the payload
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: escape state machine and burst building
  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push)
  );

  // queue of bursts
  jsu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // back: byte serialiser and output register
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

// ===== hw/rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks escape state and turns each request into a burst.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output slot_t      push
);

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic [7:0]  held_digits [3];
  logic        held_we;
  logic [1:0]  held;
  logic [4:0]  hex;
  logic        hex_ok;
  logic        bs_start;
  logic [15:0] cp;
  desc_t       desc;

  assign hex         = hex_decode(in_byte);
  assign hex_ok      = hex[4];
  assign held        = 2'(mode - MODE_HEX0);
  assign bs_start    = (in_byte == CH_BSLASH) && !in_last;
  assign cp          = {acc, hex[3:0]};

  // next state
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    held_we   = 1'b0;
    unique case (mode)
      MODE_ESC: begin
        if (in_byte == CH_U && !in_last) begin
          mode_next = MODE_HEX0;
          acc_next  = 12'd0;
        end else begin
          mode_next = MODE_PLAIN;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (hex_ok && held == 2'd3) begin
          mode_next = MODE_PLAIN;
          acc_next  = 12'd0;
        end else if (hex_ok && !in_last) begin
          mode_next = mode_t'(mode + 3'd1);
          acc_next  = {acc[7:0], hex[3:0]};
          held_we   = 1'b1;
        end else begin
          acc_next  = 12'd0;
          mode_next = bs_start ? MODE_ESC : MODE_PLAIN;
        end
      end
      default: begin
        mode_next = bs_start ? MODE_ESC : MODE_PLAIN;
      end
    endcase
    if (in_last) begin
      mode_next = MODE_PLAIN;
      acc_next  = 12'd0;
    end
  end

  // outputs
  always_comb begin
    desc.data  = '0;
    desc.count = '0;
    desc.last  = in_last;
    unique case (mode)
      MODE_ESC: begin
        desc.count = CNT_W'(1);
        unique case (in_byte)
          CH_N:    desc.data[0] = CTRL_LF;
          CH_T:    desc.data[0] = CTRL_HT;
          CH_R:    desc.data[0] = CTRL_CR;
          CH_B:    desc.data[0] = CTRL_BS;
          CH_F:    desc.data[0] = CTRL_FF;
          CH_U: begin
            desc.data[0] = CH_U;
            desc.count   = in_last ? CNT_W'(1) : CNT_W'(0);
          end
          default: desc.data[0] = in_byte;
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (hex_ok && held == 2'd3) begin
          if (cp < UTF8_ONE_LIM) begin
            desc.data[0] = cp[7:0];
            desc.count   = CNT_W'(1);
          end else if (cp < UTF8_TWO_LIM) begin
            desc.data[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            desc.data[1] = UTF8_CONT | {2'd0, cp[5:0]};
            desc.count   = CNT_W'(2);
          end else begin
            desc.data[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            desc.data[1] = UTF8_CONT | {2'd0, cp[11:6]};
            desc.data[2] = UTF8_CONT | {2'd0, cp[5:0]};
            desc.count   = CNT_W'(3);
          end
        end else if (!(hex_ok && !in_last)) begin
          // give up on the escape: 'u', held digits, then the byte itself unless it opens a new escape
          desc.data[0] = CH_U;
          for (int k = 1; k < BURST_MAX - 1; k++) begin
            desc.data[k] = (k <= int'(held)) ? held_digits[k-1] : in_byte;
          end
          desc.data[BURST_MAX-1] = in_byte;
          desc.count = CNT_W'(1) + CNT_W'(held) + CNT_W'(!bs_start);
        end
      end
      default: begin
        desc.data[0] = in_byte;
        desc.count  = bs_start ? CNT_W'(0) : CNT_W'(1);
      end
    endcase
  end

  assign push.valid = accept && (desc.count != '0);
  assign push.desc  = desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      acc  <= 12'd0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_digits[held] <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short descriptor fifo between the decoder and the serialiser.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  slot_t push,
  input  logic  pop,
  output logic  full,
  output slot_t head
);

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign do_push    = push.valid && !full;
  assign head.valid = (count != '0);
  assign head.desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Serialiser: sends the bytes of the head descriptor one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  slot_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             fin;

  assign load = head.valid && (!out_valid || out_ready);
  assign fin  = (CNT_W'(idx) + CNT_W'(1)) == head.desc.count;
  assign pop  = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= fin ? '0 : idx + IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.desc.data[idx];
      run_last   <= fin;
      string_end <= fin && head.desc.last;
    end
  end

endmodule

// ===== hw/rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_end
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(run_last) && $stable(string_end))
    else $error("stalled result changed");

  // end of string only on the last byte of a request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string_end without run_last");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // input only backs up while output holds pending data
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .string_end (string_end)
);

// ===== tb/json_string_unescape_utf8_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_test
// Self-checking bench for the JSON string unescaper with UTF-8 output.
// A short table of requests covers the byte extremes, the n, t, r, b, f and
// slash escapes and unicode cases. A random part follows, made mostly of
// well-formed strings with random content. Each result is checked against
// the table or a behavioural model that runs in step with accepted requests.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_test;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES   = 200000;
  localparam int RANDOM_ITEMS   = 440;
  localparam int HOLD_AT        = 150;   // request count that triggers the long stall
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // one expected result byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } out_rec_t;

  // one row of the directed table; n < 0 leaves the result to the model
  typedef struct {
    logic [7:0]  b;
    logic        l;
    int          n;
    logic [31:0] want;
  } step_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  // model state
  mode_t       esc_mode = MODE_PLAIN;
  logic [11:0] hex_acc = 12'h000;
  logic [7:0]  held_q [0:2];
  logic [7:0]  burst [0:7];
  int          burst_n;

  out_rec_t  owed [$];
  step_row_t script [$];

  int  errors = 0;
  int  cycles = 0;
  int  requests = 0;
  int  strings = 0;
  int  checked = 0;
  int  uni_ok = 0;
  int  uni_broken = 0;
  bit  calm_in = 0;
  bit  calm_out = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;

  json_string_unescape_utf8_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard, counts every cycle from the start
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d results still owed", $time, owed.size());
      $display("json_string_unescape_utf8_top_test: done, errors");
      $finish;
    end
  end

  // value of a hex digit, or -1 for anything else
  function automatic int digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input int v, input int upper);
    if (v < 10) return 8'h30 + 8'(v);
    return ((upper != 0) ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  function automatic void emit(input logic [7:0] c);
    burst[burst_n] = c;
    burst_n++;
  endfunction

  // advance the model by one request and leave the bytes it releases in burst
  function automatic void unescape_byte(input logic [7:0] b, input logic l);
    int          v;
    int          held;
    int          i;
    bit          as_plain;
    logic [15:0] cp;
    burst_n  = 0;
    as_plain = 0;
    v = digit_value(b);
    case (esc_mode)
      MODE_ESC: begin
        esc_mode = MODE_PLAIN;
        case (b)
          CH_N: emit(CTRL_LF);
          CH_T: emit(CTRL_HT);
          CH_R: emit(CTRL_CR);
          CH_B: emit(CTRL_BS);
          CH_F: emit(CTRL_FF);
          CH_U: begin
            if (l) begin
              emit(CH_U);
            end else begin
              esc_mode = MODE_HEX0;
              hex_acc  = 12'h000;
            end
          end
          default: emit(b);
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        held = int'(esc_mode - MODE_HEX0);
        if (v >= 0 && held == 3) begin
          // fourth digit completes the code point, even on the last byte
          cp = {hex_acc, v[3:0]};
          if (cp < UTF8_ONE_LIM) begin
            emit(cp[7:0]);
          end else if (cp < UTF8_TWO_LIM) begin
            emit(UTF8_LEAD2 | {3'b000, cp[10:6]});
            emit(UTF8_CONT | {2'b00, cp[5:0]});
          end else begin
            emit(UTF8_LEAD3 | {4'h0, cp[15:12]});
            emit(UTF8_CONT | {2'b00, cp[11:6]});
            emit(UTF8_CONT | {2'b00, cp[5:0]});
          end
          esc_mode = MODE_PLAIN;
          hex_acc  = 12'h000;
          uni_ok++;
        end else if (v >= 0 && !l) begin
          held_q[held] = b;
          hex_acc  = {hex_acc[7:0], v[3:0]};
          esc_mode = mode_t'(esc_mode + 3'd1);
        end else begin
          // bad digit or early end: give back the escape literally
          emit(CH_U);
          for (i = 0; i < held; i++) emit(held_q[i]);
          hex_acc  = 12'h000;
          as_plain = 1;
          uni_broken++;
        end
      end
      default: as_plain = 1;
    endcase
    if (as_plain) begin
      if (b == CH_BSLASH && !l) begin
        esc_mode = MODE_ESC;
      end else begin
        emit(b);
        esc_mode = MODE_PLAIN;
      end
    end
    if (l) begin
      esc_mode = MODE_PLAIN;
      hex_acc  = 12'h000;
    end
  endfunction

  // offer one request, wait for it to be taken, then queue what it owes
  task automatic offer(input logic [7:0] b, input logic l, input int n_typed,
                       input logic [31:0] want);
    int       gap;
    int       i;
    out_rec_t r;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (!in_ready);
    unescape_byte(b, l);
    if (n_typed >= 0) begin
      burst_n = n_typed;
      for (i = 0; i < n_typed; i++) burst[i] = want[8*i +: 8];
    end
    for (i = 0; i < burst_n; i++) begin
      r.data       = burst[i];
      r.run_last   = (i == burst_n - 1);
      r.string_end = r.run_last && l;
      owed.insert(owed.size(), r);
    end
    requests++;
    if (l) strings++;
  endtask

  function automatic void add_step(input logic [7:0] b, input logic l, input int n,
                                   input logic [7:0] w0 = 8'h00,
                                   input logic [7:0] w1 = 8'h00,
                                   input logic [7:0] w2 = 8'h00,
                                   input logic [7:0] w3 = 8'h00);
    step_row_t s;
    s.b    = b;
    s.l    = l;
    s.n    = n;
    s.want = {w3, w2, w1, w0};
    script.insert(script.size(), s);
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 8))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_N;
      4: return CH_T;
      5: return CH_R;
      6: return CH_B;
      7: return CH_F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random string: mostly well-formed segments, now and then pure noise
  task automatic send_string();
    logic [7:0] txt [$];
    logic [7:0] c;
    int         segs;
    int         kind;
    int         cp;
    int         i;
    segs    = $urandom_range(1, 8);
    calm_in = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 4) == 0) begin
      // noise biased towards escape characters and digits
      repeat (2 * segs) begin
        case ($urandom_range(0, 3))
          0: txt.insert(txt.size(), CH_BSLASH);
          1: txt.insert(txt.size(), CH_U);
          2: txt.insert(txt.size(), hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
          default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      repeat (segs) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_BSLASH) c = CH_U;
          txt.insert(txt.size(), c);
        end else if (kind < 60) begin
          txt.insert(txt.size(), CH_BSLASH);
          txt.insert(txt.size(), escape_char());
        end else if (kind < 85) begin
          // code point drawn from each utf-8 length class
          case ($urandom_range(0, 2))
            0: cp = $urandom_range(0, 'h7F);
            1: cp = $urandom_range('h80, 'h7FF);
            default: cp = $urandom_range('h800, 'hFFFF);
          endcase
          txt.insert(txt.size(), CH_BSLASH);
          txt.insert(txt.size(), CH_U);
          for (i = 3; i >= 0; i--)
            txt.insert(txt.size(), hex_char((cp >> (4 * i)) & 15, $urandom_range(0, 1)));
        end else begin
          // broken unicode escape: some digits then a non-digit
          txt.insert(txt.size(), CH_BSLASH);
          txt.insert(txt.size(), CH_U);
          repeat ($urandom_range(0, 3))
            txt.insert(txt.size(), hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
          do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0);
          txt.insert(txt.size(), c);
        end
      end
      // sometimes the string stops in the middle of an escape
      if ($urandom_range(0, 9) == 0) begin
        txt.insert(txt.size(), CH_BSLASH);
        if ($urandom_range(0, 1)) begin
          txt.insert(txt.size(), CH_U);
          repeat ($urandom_range(0, 3))
            txt.insert(txt.size(), hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
        end
      end
    end
    for (i = 0; i < txt.size(); i++) offer(txt[i], i == txt.size() - 1, -1, 32'h0);
  endtask

  // result side: random readiness, quiet stretches, one long stall on request
  initial begin
    int w;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      if (taken % 32 == 0) calm_out = ($urandom_range(0, 3) == 0);
      w = calm_out ? 0 : $urandom_range(0, 3);
      if (w != 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // compare each result taken with the oldest one owed
  always @(posedge clk) begin
    out_rec_t e;
    if (!rst && out_valid && out_ready) begin
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %02h run_last %0b end %0b",
                 $time, out_byte, run_last, string_end);
        errors++;
      end else begin
        e = owed.pop_front();
        checked++;
        if (out_byte !== e.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, e.data, out_byte);
          errors++;
        end
        if (run_last !== e.run_last) begin
          $display("%0t: run_last expected %0b actual %0b", $time, e.run_last, run_last);
          errors++;
        end
        if (string_end !== e.string_end) begin
          $display("%0t: string_end expected %0b actual %0b", $time, e.string_end,
                   string_end);
          errors++;
        end
      end
    end
  end

  initial begin
    int i;
    int directed;

    // byte extremes, the n, t, r, b, f and slash escapes, then unicode cases
    add_step(8'h00, 1'b0, 1, 8'h00);
    add_step(8'hFF, 1'b0, 1, 8'hFF);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_N, 1'b0, 1, CTRL_LF);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_T, 1'b0, 1, CTRL_HT);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_R, 1'b0, 1, CTRL_CR);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_B, 1'b0, 1, CTRL_BS);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_F, 1'b0, 1, CTRL_FF);
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_SLASH, 1'b0, -1);
    // highest code point, mixed case digits, three-byte form
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_U, 1'b0, 0);
    add_step(8'h46, 1'b0, 0);
    add_step(8'h46, 1'b0, 0);
    add_step(8'h46, 1'b0, 0);
    add_step(8'h66, 1'b0, 3, 8'hEF, 8'hBF, 8'hBF);
    // bad digit after two held digits gives the escape back literally
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_U, 1'b0, 0);
    add_step(8'h30, 1'b0, 0);
    add_step(8'h37, 1'b0, 0);
    add_step(8'h7A, 1'b0, 4, CH_U, 8'h30, 8'h37, 8'h7A);
    // string ends right after backslash-u, then a lone backslash string
    add_step(CH_BSLASH, 1'b0, 0);
    add_step(CH_U, 1'b1, 1, CH_U);
    add_step(CH_BSLASH, 1'b1, 1, CH_BSLASH);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < script.size(); i++)
      offer(script[i].b, script[i].l, script[i].n, script[i].want);
    directed = requests;

    while (requests < directed + RANDOM_ITEMS) begin
      if (requests >= HOLD_AT && !hold_done) begin
        hold_req  = 1;
        hold_done = 1;
      end
      send_string();
    end
    in_valid <= 1'b0;

    while (owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d from the table) in %0d strings, %0d bytes compared",
             requests, directed, strings, checked);
    $display("unicode escapes: %0d decoded, %0d given back literally; one long output stall",
             uni_ok, uni_broken);
    if (errors == 0) begin
      $display("json_string_unescape_utf8_top_test: done, clean");
    end else begin
      $display("json_string_unescape_utf8_top_test: done, errors");
    end
    $finish;
  end

endmodule
